FILE: src/jsu_pkg.sv
// Shared types, codes and a helper function for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    ST_BYTE              = 3'd0,
    ST_DONE              = 3'd1,
    ST_CONTROL           = 3'd2,
    ST_UNFINISHED_ESCAPE = 3'd3,
    ST_UNKNOWN_ESCAPE    = 3'd4,
    ST_BAD_HEX           = 3'd5,
    ST_UNFINISHED_UNI    = 3'd6,
    ST_UNTERMINATED      = 3'd7
  } status_t;

  typedef enum logic [5:0] {
    M_PLAIN = 6'b000001,
    M_ESC   = 6'b000010,
    M_HEX1  = 6'b000100,
    M_HEX2  = 6'b001000,
    M_HEX3  = 6'b010000,
    M_HEX4  = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Decoded results of one input word: up to three output words.
  typedef struct packed {
    logic [1:0]      cnt;
    status_t         status;
    logic [2:0][7:0] bytes;
  } res_t;

  // Bit 4 set when c is a hex digit; low bits hold its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: src/json_string_unescaper.sv
// JSON string unescaper top level: decoder feeding a result register.
// Latency: first result word is on m_tdata the cycle after its input word is accepted.
// Throughput: one input word per cycle while m_tready is high; a \u escape giving two or three
// UTF-8 bytes holds s_tready low until its last byte has been taken.
// Input words consumed without a result (backslash, u, first three hex digits) load nothing.
// Synchronous reset returns the decoder to plain mode and empties the result register.
module json_string_unescaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // input_ended
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_tlast    // last_of_item
);
  import jsu_pkg::*;

  res_t res;
  logic accept;
  logic can_load;

  assign s_tready = can_load;
  assign accept = s_tvalid && s_tready;

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_value  (s_tdata),
    .input_ended (s_tuser),
    .res         (res)
  );

  jsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res.cnt != 2'd0),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: src/jsu_decode.sv
// Escape decoder: mode and hex digit registers plus per-word decode logic.
module jsu_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    byte_value,
  input  logic          input_ended,
  output jsu_pkg::res_t res
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  logic [4:0]  hv;
  logic [15:0] cp;

  assign hv = hex_val(byte_value);
  assign cp = {acc, hv[3:0]};

  always_comb begin
    mode_next = mode;
    acc_next = acc;
    res.cnt = 2'd0;
    res.status = ST_BYTE;
    res.bytes = '0;
    if (input_ended) begin
      res.cnt = 2'd1;
      mode_next = M_PLAIN;
      acc_next = '0;
      case (mode)
        M_ESC: res.status = ST_UNFINISHED_ESCAPE;
        M_HEX1, M_HEX2, M_HEX3, M_HEX4: res.status = ST_UNFINISHED_UNI;
        default: res.status = ST_UNTERMINATED;
      endcase
    end else begin
      case (mode)
        M_ESC: begin
          mode_next = M_PLAIN;
          res.cnt = 2'd1;
          case (byte_value)
            CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = byte_value;
            8'h62: res.bytes[0] = 8'h08;
            8'h66: res.bytes[0] = 8'h0C;
            8'h6E: res.bytes[0] = 8'h0A;
            8'h72: res.bytes[0] = 8'h0D;
            8'h74: res.bytes[0] = 8'h09;
            8'h75: begin
              res.cnt = 2'd0;
              mode_next = M_HEX1;
              acc_next = '0;
            end
            default: begin
              res.status = ST_UNKNOWN_ESCAPE;
              acc_next = '0;
            end
          endcase
        end
        M_HEX1, M_HEX2, M_HEX3, M_HEX4: begin
          if (!hv[4]) begin
            res.cnt = 2'd1;
            res.status = ST_BAD_HEX;
            mode_next = M_PLAIN;
            acc_next = '0;
          end else if (mode == M_HEX4) begin
            mode_next = M_PLAIN;
            acc_next = '0;
            if (cp <= 16'h007F) begin
              res.cnt = 2'd1;
              res.bytes[0] = cp[7:0];
            end else if (cp <= 16'h07FF) begin
              res.cnt = 2'd2;
              res.bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
              res.bytes[1] = 8'h80 | {2'd0, cp[5:0]};
            end else begin
              res.cnt = 2'd3;
              res.bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
              res.bytes[1] = 8'h80 | {2'd0, cp[11:6]};
              res.bytes[2] = 8'h80 | {2'd0, cp[5:0]};
            end
          end else begin
            acc_next = {acc[7:0], hv[3:0]};
            mode_next = mode_t'({mode[4:0], 1'b0});
          end
        end
        default: begin
          mode_next = M_PLAIN;
          if (byte_value == CH_QUOTE) begin
            res.cnt = 2'd1;
            res.status = ST_DONE;
            acc_next = '0;
          end else if (byte_value < CH_SPACE) begin
            res.cnt = 2'd1;
            res.status = ST_CONTROL;
            acc_next = '0;
          end else if (byte_value == CH_BSLASH) begin
            mode_next = M_ESC;
          end else begin
            res.cnt = 2'd1;
            res.bytes[0] = byte_value;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_PLAIN;
      acc <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc <= acc_next;
    end
  end

endmodule

FILE: src/jsu_emit.sv
// Result register: holds one decoded bundle and sends it out word by word.
module jsu_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  jsu_pkg::res_t res,
  output logic          can_load,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic          m_tlast   // last_of_item
);
  import jsu_pkg::*;

  res_t       bund;
  logic       valid;
  logic [1:0] idx;
  logic       last;
  logic       take;

  assign last = (idx == bund.cnt - 2'd1);
  assign take = valid && m_tready;
  assign can_load = !valid || (take && last);

  assign m_tvalid = valid;
  assign m_tdata = {5'd0, bund.status, bund.bytes[idx]};
  assign m_tlast = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx <= 2'd0;
    end else if (take) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid |-> bund.cnt != 2'd0)
    else $error("bundle held with no words");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx < bund.cnt)
    else $error("word index past bundle size");
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (valid && bund.status != ST_BYTE) |-> bund.cnt == 2'd1)
    else $error("status word not alone");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!valid || (take && last)))
    else $error("bundle overwritten before drained");
`endif

endmodule
